// File: rtl/core/modbus_rtu_frame_engine_assert.svh
// Assertion macros shared by the frame engine RTL.
`ifndef MODBUS_RTU_FRAME_ENGINE_ASSERT_SVH
`define MODBUS_RTU_FRAME_ENGINE_ASSERT_SVH

// Implication or plain property, sampled on clock, off during reset.
`define MBRFE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never hold.
`define MBRFE_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// File: rtl/core/mbrfe_pkg.sv
// Shared types, constants and the CRC-16 byte update for the frame engine.
package mbrfe_pkg;

   localparam int unsigned MAX_REQUEST_BYTES = 252;
   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'hA001;
   localparam logic [7:0]  PAYLOAD_LIMIT     = 8'd250;
   localparam logic [8:0]  COUNT_MAX         = 9'd511;
   localparam logic [8:0]  REPLY_OVERHEAD    = 9'd4;
   localparam logic [6:0]  FUNC_CODE_MASK    = 7'h7F;

   localparam int unsigned MODE_W   = 2;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned CSR_ADDR_W = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_REQUEST = 2'd0,
      MODE_REPLY   = 2'd1,
      MODE_TIMEOUT = 2'd2,
      MODE_UNUSED  = 2'd3
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_TX      = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_STATUS  = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_REQUEST_LONG = 3'd1,
      ST_OVERFLOW     = 3'd2,
      ST_NO_REPLY     = 3'd3,
      ST_SHORT        = 3'd4,
      ST_CRC          = 3'd5,
      ST_INVALID      = 3'd6,
      ST_REFUSED      = 3'd7
   } status_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MAX_REPLY_PAYLOAD = 2'd0,
      CSR_CRC_SWAPPED       = 2'd1
   } csr_addr_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] out_byte;
      status_type        status;
      logic              end_of_run;
   } result_type;

   function automatic result_type make_result(kind_type k, logic [BYTE_W-1:0] b,
                                              status_type s, logic eor);
      result_type r;
      r.kind       = k;
      r.out_byte   = b;
      r.status     = s;
      r.end_of_run = eor;
      return r;
   endfunction

   // Reflected CRC-16, one byte, eight shift steps.
   function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [BYTE_W-1:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: rtl/core/mbrfe_req_if.sv
// Input channel: one request byte, reply byte or timeout event per beat.
interface mbrfe_req_if;
   logic                               valid;
   logic                               ready;
   logic [mbrfe_pkg::MODE_W-1:0]       mode;
   logic [mbrfe_pkg::BYTE_W-1:0]       data_byte;
   logic                               last;

   modport source (output valid, output mode, output data_byte, output last, input ready);
   modport sink   (input valid, input mode, input data_byte, input last, output ready);
endinterface

// File: rtl/core/mbrfe_rsp_if.sv
// Result channel: transmit bytes, reply payload bytes and final status.
interface mbrfe_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [mbrfe_pkg::KIND_W-1:0]       kind;
   logic [mbrfe_pkg::BYTE_W-1:0]       out_byte;
   logic [mbrfe_pkg::STATUS_W-1:0]     status;
   logic                               end_of_run;

   modport source (output valid, output kind, output out_byte, output status,
                   output end_of_run, input ready);
   modport sink   (input valid, input kind, input out_byte, input status,
                   input end_of_run, output ready);
endinterface

// File: rtl/core/mbrfe_csr_if.sv
// Configuration write channel.
interface mbrfe_csr_if;
   logic                               valid;
   logic                               ready;
   logic [mbrfe_pkg::CSR_ADDR_W-1:0]   addr;
   logic [mbrfe_pkg::BYTE_W-1:0]       wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// File: rtl/core/modbus_rtu_frame_engine.sv
// Modbus RTU frame engine: request CRC append and reply check, one byte per beat.
// Takes one input beat per cycle while each beat yields one result and output is
// free; results pass the bundle, then the output register. A final request byte
// yields up to three results (byte plus two CRC bytes), a last reply byte up to two;
// these leave via the single output register one per cycle when free, and the input
// stalls till the last leaves. Byte count, CRC and latched fields update at input
// acceptance, so back-to-back bytes of one frame need no bypass. No clearing pass
// after reset. Config writes are always taken (csr_chan.ready is tied high).
module modbus_rtu_frame_engine (
   input logic        clock,
   input logic        reset,
   mbrfe_req_if.sink  req_chan,
   mbrfe_rsp_if.source rsp_chan,
   mbrfe_csr_if.sink  csr_chan
);

   // Config
   logic [7:0]  max_payload_ff, max_payload_in;
   logic        crc_swapped_ff, crc_swapped_in;

   // Frame state
   logic [15:0] running_crc_ff, running_crc_in;
   logic [15:0] crc_hist0_ff, crc_hist0_in;
   logic [15:0] crc_hist1_ff, crc_hist1_in;
   logic [8:0]  byte_count_ff, byte_count_in;
   logic [7:0]  lat_addr_ff, lat_addr_in;
   logic [7:0]  lat_func_ff, lat_func_in;
   logic [7:0]  rep_addr_ff, rep_addr_in;
   logic [7:0]  rep_func_ff, rep_func_in;
   logic [7:0]  dly0_ff, dly0_in;
   logic [7:0]  dly1_ff, dly1_in;

   // Result bundle of the latest item, drained from entry 0
   mbrfe_pkg::result_type bund_ff [3];
   mbrfe_pkg::result_type bund_in [3];
   logic [1:0]  bund_cnt_ff, bund_cnt_in;

   // Output register
   mbrfe_pkg::result_type rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        out_free;
   logic        pop;
   logic        accept;
   logic [15:0] new_crc;
   logic [8:0]  count_next;
   logic [7:0]  m_eff;
   logic [8:0]  m_limit;
   logic        emit;
   logic [7:0]  crc_lo;
   logic [7:0]  crc_hi;
   logic [7:0]  chk_first;
   logic [7:0]  chk_second;
   logic [7:0]  raddr_eff;
   logic [7:0]  rfunc_eff;
   mbrfe_pkg::status_type reply_st;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop      = (bund_cnt_ff != 2'd0) && out_free;
   assign req_chan.ready = (bund_cnt_ff == 2'd0) || ((bund_cnt_ff == 2'd1) && out_free);
   assign accept   = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign new_crc    = mbrfe_pkg::crc16_byte(running_crc_ff, req_chan.data_byte);
   assign count_next = (byte_count_ff == mbrfe_pkg::COUNT_MAX) ? byte_count_ff
                                                               : byte_count_ff + 9'd1;
   assign m_eff      = (max_payload_ff > mbrfe_pkg::PAYLOAD_LIMIT) ? mbrfe_pkg::PAYLOAD_LIMIT
                                                                   : max_payload_ff;
   assign m_limit    = {1'b0, m_eff} + mbrfe_pkg::REPLY_OVERHEAD;
   assign emit       = (byte_count_ff >= mbrfe_pkg::REPLY_OVERHEAD) &&
                       (byte_count_ff < m_limit);
   assign crc_lo     = new_crc[7:0];
   assign crc_hi     = new_crc[15:8];
   // Received CRC is checked against the CRC before the two latest bytes
   assign chk_first  = crc_swapped_ff ? crc_hist0_ff[7:0] : crc_hist0_ff[15:8];
   assign chk_second = crc_swapped_ff ? crc_hist0_ff[15:8] : crc_hist0_ff[7:0];
   assign raddr_eff  = (byte_count_ff == 9'd0) ? req_chan.data_byte : rep_addr_ff;
   assign rfunc_eff  = (byte_count_ff == 9'd1) ? req_chan.data_byte : rep_func_ff;

   always_comb begin
      if (count_next > m_limit) begin
         reply_st = mbrfe_pkg::ST_OVERFLOW;
      end else if (count_next < mbrfe_pkg::REPLY_OVERHEAD) begin
         reply_st = mbrfe_pkg::ST_SHORT;
      end else if ((dly0_ff != chk_first) || (req_chan.data_byte != chk_second)) begin
         reply_st = mbrfe_pkg::ST_CRC;
      end else if ((raddr_eff != lat_addr_ff) &&
                   (((rfunc_eff[6:0] ^ lat_func_ff[6:0]) &
                     mbrfe_pkg::FUNC_CODE_MASK) != 7'd0)) begin
         reply_st = mbrfe_pkg::ST_INVALID;
      end else if (rfunc_eff != lat_func_ff) begin
         reply_st = mbrfe_pkg::ST_REFUSED;
      end else begin
         reply_st = mbrfe_pkg::ST_OK;
      end
   end

   // Config writes
   always_comb begin
      max_payload_in = max_payload_ff;
      crc_swapped_in = crc_swapped_ff;
      if (csr_chan.valid) begin
         case (csr_chan.addr)
            mbrfe_pkg::CSR_MAX_REPLY_PAYLOAD: max_payload_in = csr_chan.wdata;
            mbrfe_pkg::CSR_CRC_SWAPPED:       crc_swapped_in = csr_chan.wdata[0];
            default: ;
         endcase
      end
   end

   // Frame state and result bundle
   always_comb begin
      running_crc_in = running_crc_ff;
      crc_hist0_in   = crc_hist0_ff;
      crc_hist1_in   = crc_hist1_ff;
      byte_count_in  = byte_count_ff;
      lat_addr_in    = lat_addr_ff;
      lat_func_in    = lat_func_ff;
      rep_addr_in    = rep_addr_ff;
      rep_func_in    = rep_func_ff;
      dly0_in        = dly0_ff;
      dly1_in        = dly1_ff;
      bund_in[0]     = bund_ff[0];
      bund_in[1]     = bund_ff[1];
      bund_in[2]     = bund_ff[2];
      bund_cnt_in    = bund_cnt_ff;

      if (pop) begin
         bund_in[0]  = bund_ff[1];
         bund_in[1]  = bund_ff[2];
         bund_cnt_in = bund_cnt_ff - 2'd1;
      end

      if (accept) begin
         bund_cnt_in = 2'd0;
         if ((req_chan.mode == mbrfe_pkg::MODE_REQUEST) ||
             (req_chan.mode == mbrfe_pkg::MODE_REPLY)) begin
            crc_hist1_in   = crc_hist0_ff;
            crc_hist0_in   = running_crc_ff;
            running_crc_in = new_crc;
            dly1_in        = dly0_ff;
            dly0_in        = req_chan.data_byte;
            byte_count_in  = count_next;
         end
         case (req_chan.mode)
            mbrfe_pkg::MODE_REQUEST: begin
               if (byte_count_ff == 9'd0) begin
                  lat_addr_in = req_chan.data_byte;
               end else if (byte_count_ff == 9'd1) begin
                  lat_func_in = req_chan.data_byte;
               end
               bund_in[0]  = mbrfe_pkg::make_result(mbrfe_pkg::KIND_TX, req_chan.data_byte,
                                                    mbrfe_pkg::ST_OK, !req_chan.last);
               bund_cnt_in = 2'd1;
               if (req_chan.last) begin
                  if (count_next > 9'(mbrfe_pkg::MAX_REQUEST_BYTES)) begin
                     bund_in[1]  = mbrfe_pkg::make_result(mbrfe_pkg::KIND_STATUS, 8'd0,
                                                          mbrfe_pkg::ST_REQUEST_LONG, 1'b1);
                     bund_cnt_in = 2'd2;
                  end else begin
                     bund_in[1]  = mbrfe_pkg::make_result(mbrfe_pkg::KIND_TX,
                                      crc_swapped_ff ? crc_lo : crc_hi,
                                      mbrfe_pkg::ST_OK, 1'b0);
                     bund_in[2]  = mbrfe_pkg::make_result(mbrfe_pkg::KIND_TX,
                                      crc_swapped_ff ? crc_hi : crc_lo,
                                      mbrfe_pkg::ST_OK, 1'b1);
                     bund_cnt_in = 2'd3;
                  end
               end
            end
            mbrfe_pkg::MODE_REPLY: begin
               rep_addr_in = raddr_eff;
               rep_func_in = rfunc_eff;
               if (emit) begin
                  // payload runs two bytes behind, so the CRC bytes never go out
                  bund_in[0]  = mbrfe_pkg::make_result(mbrfe_pkg::KIND_PAYLOAD, dly1_ff,
                                                       mbrfe_pkg::ST_OK, !req_chan.last);
                  bund_in[1]  = mbrfe_pkg::make_result(mbrfe_pkg::KIND_STATUS, 8'd0,
                                                       reply_st, 1'b1);
                  bund_cnt_in = req_chan.last ? 2'd2 : 2'd1;
               end else begin
                  bund_in[0]  = mbrfe_pkg::make_result(mbrfe_pkg::KIND_STATUS, 8'd0,
                                                       reply_st, 1'b1);
                  bund_cnt_in = req_chan.last ? 2'd1 : 2'd0;
               end
            end
            mbrfe_pkg::MODE_TIMEOUT: begin
               bund_in[0]  = mbrfe_pkg::make_result(mbrfe_pkg::KIND_STATUS, 8'd0,
                                                    mbrfe_pkg::ST_NO_REPLY, 1'b1);
               bund_cnt_in = 2'd1;
            end
            default: ;
         endcase

         if ((req_chan.mode == mbrfe_pkg::MODE_TIMEOUT) ||
             (req_chan.last && ((req_chan.mode == mbrfe_pkg::MODE_REQUEST) ||
                                (req_chan.mode == mbrfe_pkg::MODE_REPLY)))) begin
            running_crc_in = mbrfe_pkg::CRC_INIT;
            crc_hist0_in   = mbrfe_pkg::CRC_INIT;
            crc_hist1_in   = mbrfe_pkg::CRC_INIT;
            byte_count_in  = 9'd0;
            dly0_in        = 8'd0;
            dly1_in        = 8'd0;
         end
      end
   end

   // Output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_in       = bund_ff[0];
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= mbrfe_pkg::PAYLOAD_LIMIT;
         crc_swapped_ff <= 1'b1;
         running_crc_ff <= mbrfe_pkg::CRC_INIT;
         crc_hist0_ff   <= mbrfe_pkg::CRC_INIT;
         crc_hist1_ff   <= mbrfe_pkg::CRC_INIT;
         byte_count_ff  <= 9'd0;
         lat_addr_ff    <= 8'd0;
         lat_func_ff    <= 8'd0;
         rep_addr_ff    <= 8'd0;
         rep_func_ff    <= 8'd0;
         dly0_ff        <= 8'd0;
         dly1_ff        <= 8'd0;
         bund_cnt_ff    <= 2'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         max_payload_ff <= max_payload_in;
         crc_swapped_ff <= crc_swapped_in;
         running_crc_ff <= running_crc_in;
         crc_hist0_ff   <= crc_hist0_in;
         crc_hist1_ff   <= crc_hist1_in;
         byte_count_ff  <= byte_count_in;
         lat_addr_ff    <= lat_addr_in;
         lat_func_ff    <= lat_func_in;
         rep_addr_ff    <= rep_addr_in;
         rep_func_ff    <= rep_func_in;
         dly0_ff        <= dly0_in;
         dly1_ff        <= dly1_in;
         bund_cnt_ff    <= bund_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bund_ff[0] <= bund_in[0];
      bund_ff[1] <= bund_in[1];
      bund_ff[2] <= bund_in[2];
      rsp_ff     <= rsp_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = rsp_ff.kind;
   assign rsp_chan.out_byte   = rsp_ff.out_byte;
   assign rsp_chan.status     = rsp_ff.status;
   assign rsp_chan.end_of_run = rsp_ff.end_of_run;

`include "modbus_rtu_frame_engine_assert.svh"

   // a new beat only lands once the previous bundle is out or leaving now
   `MBRFE_ASSERT(a_accept_room,
      accept |-> (bund_cnt_ff == 2'd0) || (bund_cnt_ff == 2'd1 && out_free),
      "input beat taken over a pending bundle")
   // a result that does not end its run must have its followers queued
   `MBRFE_ASSERT(a_run_continues,
      (rsp_valid_ff && !rsp_ff.end_of_run) |-> (bund_cnt_ff != 2'd0),
      "run cut short in result path")
   // frame end restarts the count
   `MBRFE_ASSERT(a_restart,
      (accept && (req_chan.mode == mbrfe_pkg::MODE_TIMEOUT ||
                  (req_chan.last && req_chan.mode != mbrfe_pkg::MODE_UNUSED)))
         |=> (byte_count_ff == 9'd0),
      "frame end did not restart count")
   `MBRFE_NEVER(a_status_byte,
      rsp_valid_ff && rsp_ff.kind == mbrfe_pkg::KIND_STATUS && rsp_ff.out_byte != 8'd0,
      "status beat with nonzero byte")

endmodule
